// ===== src/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;

  localparam logic [1:0] REL_LESS    = 2'd0;
  localparam logic [1:0] REL_EQUAL   = 2'd1;
  localparam logic [1:0] REL_GREATER = 2'd2;

  localparam int NUM_W = 33;
  localparam int DEN_W = 31;

  // Classified operation handed from front to back
  typedef struct packed {
    logic       err;      // invalid command or zero denominator
    logic       cmp;      // compare: relation only
    logic [1:0] rel;      // precomputed relation for compare
    logic       neg;      // sign of the result numerator
    logic [64:0] nmag;    // numerator magnitude
    logic [63:0] dmag;    // denominator magnitude
  } rau_op_t;
endpackage

// ===== src/rau_front.sv =====
// Front end: accepts items, forms cross products and sign, classifies.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_front #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             cmd,
  input  logic [DATA_WIDTH-1:0]  n1_raw,
  input  logic [DATA_WIDTH-1:0]  d1_raw,
  input  logic [DATA_WIDTH-1:0]  n2_raw,
  input  logic [DATA_WIDTH-1:0]  d2_raw,
  output logic                   op_valid,
  input  logic                   op_ready,
  output rau_pkg::rau_op_t       op
);
  localparam int PW = 2 * DATA_WIDTH;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM} fstate_t;

  fstate_t             state_r;
  logic [2:0]          cmd_r;
  logic [DATA_WIDTH-1:0] n1m_r, d1m_r, n2m_r, d2m_r;
  logic                n1s_r, d1s_r, n2s_r, d2s_r;
  logic [PW-1:0]       pa_r, pb_r, pd_r;
  logic                bad_r;
  rau_pkg::rau_op_t    op_r;
  logic                opv_r;

  function automatic logic [DATA_WIDTH-1:0] mag_of(input logic [DATA_WIDTH-1:0] x);
    mag_of = x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

  logic [PW:0]  sum_w;
  logic         sneg_w;
  logic         ps_a, ps_b, ps_d;
  logic [64:0]  nm_w;
  logic [63:0]  dm_w;
  logic         nn_w, dn_w;

  assign in_ready = (state_r == F_IDLE);
  assign op_valid = opv_r;
  assign op       = op_r;

  always_comb begin
    // product signs
    ps_a = 1'b0;
    ps_b = 1'b0;
    ps_d = 1'b0;
    unique case (cmd_r)
      rau_pkg::CMD_MUL: begin
        ps_a = n1s_r ^ n2s_r;
        ps_d = d1s_r ^ d2s_r;
      end
      rau_pkg::CMD_DIV: begin
        ps_a = n1s_r ^ d2s_r;
        ps_d = d1s_r ^ n2s_r;
      end
      default: begin
        ps_a = n1s_r ^ d2s_r;
        ps_b = n2s_r ^ d1s_r;
        if (cmd_r != rau_pkg::CMD_ADD) ps_b = ~ps_b;
        ps_d = d1s_r ^ d2s_r;
      end
    endcase
    if (pa_r == '0) ps_a = 1'b0;
    if (pb_r == '0) ps_b = 1'b0;
    if (pd_r == '0) ps_d = 1'b0;
    // signed magnitude add of a and b
    if (ps_a == ps_b) begin
      sum_w  = {1'b0, pa_r} + {1'b0, pb_r};
      sneg_w = ps_a;
    end else if (pa_r >= pb_r) begin
      sum_w  = {1'b0, pa_r} - {1'b0, pb_r};
      sneg_w = ps_a;
    end else begin
      sum_w  = {1'b0, pb_r} - {1'b0, pa_r};
      sneg_w = ps_b;
    end
    if (sum_w == '0) sneg_w = 1'b0;
    nm_w = 65'(sum_w);
    dm_w = 64'(pd_r);
    dn_w = ps_d;
    nn_w = (sneg_w ^ dn_w) && (sum_w != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      opv_r   <= 1'b0;
    end else begin
      if (opv_r && op_ready && (state_r != F_SUM)) opv_r <= 1'b0;
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            cmd_r <= cmd;
            n1m_r <= mag_of(n1_raw);  n1s_r <= n1_raw[DATA_WIDTH-1];
            d1m_r <= mag_of(d1_raw);  d1s_r <= d1_raw[DATA_WIDTH-1];
            n2m_r <= mag_of(n2_raw);  n2s_r <= n2_raw[DATA_WIDTH-1];
            d2m_r <= mag_of(d2_raw);  d2s_r <= d2_raw[DATA_WIDTH-1];
            bad_r <= (cmd > rau_pkg::CMD_CMP) || (d1_raw == '0) || (d2_raw == '0);
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          // one product per multiplier, registered
          unique case (cmd_r)
            rau_pkg::CMD_MUL: begin
              pa_r <= PW'(n1m_r) * PW'(n2m_r);
              pb_r <= '0;
              pd_r <= PW'(d1m_r) * PW'(d2m_r);
            end
            rau_pkg::CMD_DIV: begin
              pa_r <= PW'(n1m_r) * PW'(d2m_r);
              pb_r <= '0;
              pd_r <= PW'(d1m_r) * PW'(n2m_r);
            end
            default: begin
              pa_r <= PW'(n1m_r) * PW'(d2m_r);
              pb_r <= PW'(n2m_r) * PW'(d1m_r);
              pd_r <= PW'(d1m_r) * PW'(d2m_r);
            end
          endcase
          state_r <= F_SUM;
        end
        default: begin
          // wait for room in the queue register
          if (!opv_r || op_ready) begin
            op_r.err  <= bad_r || (pd_r == '0);
            op_r.cmp  <= (cmd_r == rau_pkg::CMD_CMP);
            op_r.rel  <= (sum_w == '0) ? rau_pkg::REL_EQUAL :
                         (sneg_w == (d1s_r ^ d2s_r)) ? rau_pkg::REL_GREATER :
                         rau_pkg::REL_LESS;
            op_r.neg  <= nn_w;
            op_r.nmag <= nm_w;
            op_r.dmag <= dm_w;
            opv_r     <= 1'b1;
            state_r   <= F_IDLE;
          end
        end
      endcase
    end
  end
endmodule

// ===== src/rau_back.sv =====
// Back end: Euclidean GCD by bit-serial remainder, then exact divisions.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         op_valid,
  output logic                         op_ready,
  input  rau_pkg::rau_op_t             op,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rau_pkg::NUM_W-1:0]    res_num,
  output logic [rau_pkg::DEN_W-1:0]    res_den,
  output logic [1:0]                   res_rel,
  output logic                         res_err
);
  localparam int W  = 65;
  localparam int CW = 7;

  typedef enum logic [2:0] {B_IDLE, B_GCD, B_DIVN, B_DIVD, B_OUT} bstate_t;

  bstate_t        state_r;
  logic [W-1:0]   u_r, v_r, nm_r, dm_r, q_r, rem_r, dvs_r, dvd_r;
  logic [CW-1:0]  cnt_r;
  logic           neg_r;
  logic           ov_r;
  logic [rau_pkg::NUM_W-1:0] rn_r;
  logic [rau_pkg::DEN_W-1:0] rd_r;
  logic [1:0]     rr_r;
  logic           re_r;

  // one restoring division step
  logic [W:0]     trial_w;
  logic [W-1:0]   rsh_w;
  assign rsh_w   = {rem_r[W-2:0], dvd_r[W-1]};
  assign trial_w = {1'b0, rsh_w} - {1'b0, dvs_r};

  assign op_ready  = (state_r == B_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign res_num   = rn_r;
  assign res_den   = rd_r;
  assign res_rel   = rr_r;
  assign res_err   = re_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (op_valid && !ov_r) begin
            if (op.err || op.cmp) begin
              rn_r <= '0;
              rd_r <= '0;
              rr_r <= op.err ? rau_pkg::REL_LESS : op.rel;
              re_r <= op.err;
              ov_r <= 1'b1;
            end else begin
              nm_r  <= op.nmag;
              dm_r  <= {1'b0, op.dmag};
              neg_r <= op.neg;
              u_r   <= op.nmag;
              v_r   <= {1'b0, op.dmag};
              dvd_r <= op.nmag;
              dvs_r <= {1'b0, op.dmag};
              rem_r <= '0;
              cnt_r <= '0;
              state_r <= B_GCD;
            end
          end
        end
        B_GCD: begin
          // remainder u % v, one bit a cycle
          if (v_r == '0) begin
            dvd_r   <= nm_r;
            dvs_r   <= u_r;
            rem_r   <= '0;
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= B_DIVN;
          end else if (cnt_r == CW'(W)) begin
            u_r   <= v_r;
            v_r   <= rem_r;
            dvd_r <= v_r;
            dvs_r <= rem_r;
            rem_r <= '0;
            cnt_r <= '0;
          end else begin
            dvd_r <= {dvd_r[W-2:0], 1'b0};
            rem_r <= trial_w[W] ? rsh_w : trial_w[W-1:0];
            cnt_r <= cnt_r + 1'b1;
          end
        end
        B_DIVN, B_DIVD: begin
          // quotient by the gcd, one bit a cycle
          if (cnt_r == CW'(W)) begin
            if (state_r == B_DIVN) begin
              nm_r    <= q_r;
              dvd_r   <= dm_r;
              rem_r   <= '0;
              q_r     <= '0;
              cnt_r   <= '0;
              state_r <= B_DIVD;
            end else begin
              dm_r    <= q_r;
              state_r <= B_OUT;
            end
          end else begin
            dvd_r <= {dvd_r[W-2:0], 1'b0};
            rem_r <= trial_w[W] ? rsh_w : trial_w[W-1:0];
            q_r   <= {q_r[W-2:0], ~trial_w[W]};
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: begin
          if (!ov_r) begin
            rn_r <= neg_r ? rau_pkg::NUM_W'(~nm_r + 1'b1) : nm_r[rau_pkg::NUM_W-1:0];
            rd_r <= dm_r[rau_pkg::DEN_W-1:0];
            rr_r <= rau_pkg::REL_LESS;
            re_r <= 1'b0;
            ov_r <= 1'b1;
            state_r <= B_IDLE;
          end
        end
      endcase
    end
  end
endmodule

// ===== src/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit: fraction add/sub/mul/div/compare with GCD reduction.
// Compare and error items skip the GCD; arithmetic items run Euclid remainder steps
// on a 65-bit bit-serial unit, then exact divisions. The front end takes a new item
// only when idle; arithmetic items pass one at a time through the back end's shared
// divider.
// Reset: synchronous active-low rst_n clears all handshake and state control.
`timescale 1ns / 1ps
module rational_arithmetic_unit_core #(
  parameter int DATA_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[2:0], first_num[18:3], first_den[34:19], second_num[50:35],
  // second_den[66:51], zero fill to 72
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_num[32:0], result_den[63:33], relation[65:64], error[66], zero fill
  output logic [71:0] out_tdata
);
  logic             opv, opr;
  rau_pkg::rau_op_t op;
  logic [rau_pkg::NUM_W-1:0] rn;
  logic [rau_pkg::DEN_W-1:0] rd;
  logic [1:0]       rr;
  logic             re;

  // fraction fields are 16 bits wide; read them as DATA_WIDTH-bit values
  rau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (in_tdata[2:0]),
    .n1_raw   (DATA_WIDTH'(in_tdata[18:3])),
    .d1_raw   (DATA_WIDTH'(in_tdata[34:19])),
    .n2_raw   (DATA_WIDTH'(in_tdata[50:35])),
    .d2_raw   (DATA_WIDTH'(in_tdata[66:51])),
    .op_valid (opv),
    .op_ready (opr),
    .op       (op)
  );

  rau_back u_back (
    .clk, .rst_n,
    .op_valid  (opv),
    .op_ready  (opr),
    .op        (op),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_num   (rn),
    .res_den   (rd),
    .res_rel   (rr),
    .res_err   (re)
  );

  assign out_tdata = {5'd0, re, rr, rd, rn};
endmodule
